FILE: hw/rtl/gst_pkg.sv
// ----------------------------------------------------------------------------
// Feed sequence gap tracker package
// Shared types and constants for the per-contract sequence gap tracker.
// ----------------------------------------------------------------------------
package gst_pkg;

  localparam int unsigned CONTRACTS   = 256;
  localparam int unsigned IDX_W       = (CONTRACTS > 1) ? $clog2(CONTRACTS) : 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_DELTA     = 3'd0,
    CMD_SNAPSHOT  = 3'd1,
    CMD_RESYNC    = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_CLEAR_ALL = 3'd4,
    CMD_QUERY     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    SYNC_IN     = 2'd0,
    SYNC_GAP    = 2'd1,
    SYNC_RESYNC = 2'd2
  } sync_state_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  contract_id;
    logic [63:0] sequence_req;
    logic [62:0] stamp_ms;
  } in_beat_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  sync_state;
    logic [63:0] last_sequence;
    logic        sequence_known;
    logic        gap_present;
    logic        gap_event;
    logic [63:0] gap_expected;
    logic [63:0] gap_actual;
    logic [63:0] gap_count;
    logic [62:0] gap_timestamp;
    logic        resync_event;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] last;
    logic        known;
    logic        gap;
    sync_state_e sst;
  } entry_t;

  typedef struct packed {
    cmd_e             op;
    logic             id_ok;
    logic [IDX_W-1:0] idx;
    logic [63:0]      seq;
    logic [62:0]      ts;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_link_t;

endpackage

FILE: hw/rtl/gst_front.sv
// ----------------------------------------------------------------------------
// Gap tracker front end
// Accepts input beats, decodes the command and checks the contract id.
// ----------------------------------------------------------------------------
module gst_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gst_pkg::in_beat_t in_data_i,
  output logic             push_o,
  input  logic             full_i,
  output gst_pkg::item_t   item_o
);

  gst_pkg::cmd_e op;

  always_comb begin
    case (in_data_i.cmd)
      gst_pkg::CMD_DELTA:     op = gst_pkg::CMD_DELTA;
      gst_pkg::CMD_SNAPSHOT:  op = gst_pkg::CMD_SNAPSHOT;
      gst_pkg::CMD_RESYNC:    op = gst_pkg::CMD_RESYNC;
      gst_pkg::CMD_CLEAR:     op = gst_pkg::CMD_CLEAR;
      gst_pkg::CMD_CLEAR_ALL: op = gst_pkg::CMD_CLEAR_ALL;
      default:                op = gst_pkg::CMD_QUERY;
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.op    = op;
    item_o.id_ok = (32'(in_data_i.contract_id) < gst_pkg::CONTRACTS);
    item_o.idx   = gst_pkg::IDX_W'(in_data_i.contract_id);
    item_o.seq   = in_data_i.sequence_req;
    item_o.ts    = in_data_i.stamp_ms;
  end

endmodule

FILE: hw/rtl/gst_queue.sv
// ----------------------------------------------------------------------------
// Gap tracker command queue
// Short FIFO of decoded commands between the front end and the table engine.
// ----------------------------------------------------------------------------
module gst_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gst_pkg::item_t   item_i,
  output logic             full_o,
  output gst_pkg::q_link_t link_o,
  input  logic             pop_i
);

  gst_pkg::item_t               mem_q [gst_pkg::QUEUE_DEPTH];
  logic [gst_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [gst_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [gst_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                         do_push, do_pop;

  assign full_o  = (count_q == gst_pkg::QCNT_W'(gst_pkg::QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == gst_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == gst_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_comb begin
    link_o.valid = (count_q != '0);
    link_o.item  = mem_q[rd_ptr_q];
  end

endmodule

FILE: hw/rtl/gst_back.sv
// ----------------------------------------------------------------------------
// Gap tracker table engine
// Reads the contract entry, applies the command and registers the result beat.
// ----------------------------------------------------------------------------
module gst_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gst_pkg::q_link_t   link_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gst_pkg::out_beat_t out_data_o
);

  gst_pkg::back_state_e          state_q, state_d;
  gst_pkg::item_t                cur_q;
  gst_pkg::entry_t               ent_mem [gst_pkg::CONTRACTS];
  gst_pkg::entry_t               rdata_q, ent, ent_n;
  logic [gst_pkg::CONTRACTS-1:0] live_q;
  logic                          live_rd_q;
  logic                          out_valid_q;
  gst_pkg::out_beat_t            out_data_q, res;

  logic                          fire, gap_hit, is_max, clr_one, clr_all;
  logic [63:0]                   last_plus;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    fire    = 1'b0;
    case (state_q)
      gst_pkg::BK_IDLE: begin
        if (link_i.valid) begin
          pop_o   = 1'b1;
          state_d = gst_pkg::BK_EXEC;
        end
      end
      gst_pkg::BK_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          fire    = 1'b1;
          state_d = gst_pkg::BK_IDLE;
        end
      end
      default: state_d = gst_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    if (live_rd_q) begin
      ent = rdata_q;
    end else begin
      ent = '0;
    end
    ent_n     = ent;
    last_plus = ent.last + 64'd1;
    is_max    = &ent.last;
    gap_hit   = 1'b0;
    clr_one   = 1'b0;
    clr_all   = 1'b0;
    case (cur_q.op)
      gst_pkg::CMD_DELTA: begin
        if (!ent.known) begin
          ent_n.last  = cur_q.seq;
          ent_n.known = 1'b1;
          ent_n.sst   = gst_pkg::SYNC_IN;
        end else if (!is_max && (cur_q.seq > last_plus)) begin
          gap_hit   = 1'b1;
          ent_n.gap = 1'b1;
          ent_n.sst = gst_pkg::SYNC_GAP;
        end else begin
          ent_n.last = cur_q.seq;
          ent_n.sst  = gst_pkg::SYNC_IN;
        end
      end
      gst_pkg::CMD_SNAPSHOT: begin
        ent_n.last  = cur_q.seq;
        ent_n.known = 1'b1;
        ent_n.gap   = 1'b0;
        ent_n.sst   = gst_pkg::SYNC_IN;
      end
      gst_pkg::CMD_RESYNC: begin
        ent_n.sst = gst_pkg::SYNC_RESYNC;
      end
      gst_pkg::CMD_CLEAR: begin
        clr_one = 1'b1;
        ent_n   = '0;
      end
      gst_pkg::CMD_CLEAR_ALL: begin
        clr_all = 1'b1;
        ent_n   = '0;
      end
      default: ;
    endcase
    res          = '0;
    res.accepted = 1'b1;
    if (cur_q.id_ok) begin
      res.accepted       = !gap_hit;
      res.sync_state     = ent_n.sst;
      res.last_sequence  = ent_n.known ? ent_n.last : 64'd0;
      res.sequence_known = ent_n.known;
      res.gap_present    = ent_n.gap;
      res.gap_event      = gap_hit;
      res.resync_event   = (cur_q.op == gst_pkg::CMD_RESYNC);
      if (gap_hit) begin
        res.gap_expected  = last_plus;
        res.gap_actual    = cur_q.seq;
        res.gap_count     = cur_q.seq - last_plus;
        res.gap_timestamp = cur_q.ts;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gst_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      live_q      <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire && cur_q.id_ok) begin
        if (clr_all) begin
          live_q <= '0;
        end else if (clr_one) begin
          live_q[cur_q.idx] <= 1'b0;
        end else begin
          live_q[cur_q.idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q     <= link_i.item;
      rdata_q   <= ent_mem[link_i.item.idx];
      live_rd_q <= live_q[link_i.item.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && cur_q.id_ok && !clr_one && !clr_all) begin
      ent_mem[cur_q.idx] <= ent_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_gap_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.gap_event |->
      !out_data_q.accepted && out_data_q.gap_present &&
      (out_data_q.sync_state == gst_pkg::SYNC_GAP))
    else $error("Gap event without matching status.");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.sequence_known |-> (out_data_q.last_sequence == 64'd0))
    else $error("Last sequence reported for a contract without one.");

  a_resync_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.resync_event |->
      (out_data_q.sync_state == gst_pkg::SYNC_RESYNC))
    else $error("Resync event without resyncing state.");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == gst_pkg::BK_EXEC) && !pop_o)
    else $error("Command popped while another is being executed.");
`endif

endmodule

FILE: hw/rtl/feed_sequence_gap_tracker_top.sv
// ----------------------------------------------------------------------------
// Feed sequence gap tracker top level
// Per-contract feed sequence tracking with gap and resync reporting.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Payload
//  in       in_valid_i / in_ready_o   in_data_i  (cmd, contract, sequence, time)
//  out      out_valid_o / out_ready_i out_data_o (status and gap report)
//
// In the table engine, the idle state pops a command and reads its contract entry;
// the exec state, once the result register is empty or being read, updates the
// entry and registers the result beat; no command is popped while one executes.
// A two-beat queue lets the input side run ahead while the output stalls.
// Reset and a clear-all command drop a per-contract live vector at once;
// entries that are not live read as cleared, so the entry memory is never cleared.
// ----------------------------------------------------------------------------
module feed_sequence_gap_tracker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gst_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gst_pkg::out_beat_t out_data_o
);

  logic             push, full, pop;
  gst_pkg::item_t   item;
  gst_pkg::q_link_t link;

  gst_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .full_i     (full),
    .item_o     (item)
  );

  gst_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (full),
    .link_o (link),
    .pop_i  (pop)
  );

  gst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .link_i      (link),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/sv/feed_sequence_gap_tracker_top_test.sv
// ----------------------------------------------------------------------------
// Feed sequence gap tracker testbench
// Drives command beats into the tracker under random idling and output stalls,
// predicts each status beat from a local per-contract table, and compares
// every output beat field by field in order.
// ----------------------------------------------------------------------------
module feed_sequence_gap_tracker_top_test;

  localparam logic [2:0]  CMD_SPARE6 = 3'd6;
  localparam logic [2:0]  CMD_SPARE7 = 3'd7;
  localparam logic [63:0] SEQ_MAX    = '1;
  localparam logic [62:0] TS_MAX     = '1;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  gst_pkg::in_beat_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  gst_pkg::out_beat_t out_data_o;

  feed_sequence_gap_tracker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  logic [63:0]          seq_last  [gst_pkg::CONTRACTS];
  logic                 seq_known [gst_pkg::CONTRACTS];
  gst_pkg::sync_state_e sync_tab  [gst_pkg::CONTRACTS];
  logic                 gap_flag  [gst_pkg::CONTRACTS];

  gst_pkg::in_beat_t    feed_q[$];
  gst_pkg::out_beat_t   expected_status_q[$];
  logic                 in_fire   = 1'b0;
  int unsigned          beats_in  = 0;
  int unsigned          beats_out = 0;
  int unsigned          fail_count = 0;

  function automatic void forget_contract(int unsigned c);
    seq_last[c]  = '0;
    seq_known[c] = 1'b0;
    sync_tab[c]  = gst_pkg::SYNC_IN;
    gap_flag[c]  = 1'b0;
  endfunction

  function automatic gst_pkg::out_beat_t track_feed_beat(gst_pkg::in_beat_t b);
    gst_pkg::out_beat_t r;
    int unsigned        c;
    r = '0;
    r.accepted = 1'b1;
    c = 32'(b.contract_id);
    if (c >= gst_pkg::CONTRACTS) return r;
    case (b.cmd)
      gst_pkg::CMD_DELTA: begin
        if (!seq_known[c]) begin
          seq_last[c]  = b.sequence_req;
          seq_known[c] = 1'b1;
          sync_tab[c]  = gst_pkg::SYNC_IN;
        end else if (seq_last[c] != SEQ_MAX && b.sequence_req > seq_last[c] + 64'd1) begin
          r.gap_event     = 1'b1;
          r.gap_expected  = seq_last[c] + 64'd1;
          r.gap_actual    = b.sequence_req;
          r.gap_count     = b.sequence_req - seq_last[c] - 64'd1;
          r.gap_timestamp = b.stamp_ms;
          r.accepted      = 1'b0;
          gap_flag[c]     = 1'b1;
          sync_tab[c]     = gst_pkg::SYNC_GAP;
        end else begin
          seq_last[c] = b.sequence_req;
          sync_tab[c] = gst_pkg::SYNC_IN;
        end
      end
      gst_pkg::CMD_SNAPSHOT: begin
        seq_last[c]  = b.sequence_req;
        seq_known[c] = 1'b1;
        gap_flag[c]  = 1'b0;
        sync_tab[c]  = gst_pkg::SYNC_IN;
      end
      gst_pkg::CMD_RESYNC: begin
        sync_tab[c]    = gst_pkg::SYNC_RESYNC;
        r.resync_event = 1'b1;
      end
      gst_pkg::CMD_CLEAR: forget_contract(c);
      gst_pkg::CMD_CLEAR_ALL: begin
        for (int unsigned k = 0; k < gst_pkg::CONTRACTS; k++) forget_contract(k);
      end
      default: ;
    endcase
    r.sync_state     = sync_tab[c];
    r.last_sequence  = seq_known[c] ? seq_last[c] : '0;
    r.sequence_known = seq_known[c];
    r.gap_present    = gap_flag[c];
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic queue_beat(logic [2:0] op, logic [7:0] id, logic [63:0] seq, logic [62:0] ts);
    gst_pkg::in_beat_t b;
    b.cmd          = op;
    b.contract_id  = id;
    b.sequence_req = seq;
    b.stamp_ms     = ts;
    feed_q.push_back(b);
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : monitor
    gst_pkg::out_beat_t want;
    gst_pkg::out_beat_t got;
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_status_q.push_back(track_feed_beat(in_data_i));
        beats_in++;
      end
      if (out_valid_o && out_ready_i) begin
        beats_out++;
        got = out_data_o;
        if (expected_status_q.size() == 0) begin
          $error("unexpected status beat %h", got);
          fail_count++;
        end else begin
          want = expected_status_q.pop_front();
          compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
          compare_field("sync_state", 64'(want.sync_state), 64'(got.sync_state));
          compare_field("last_sequence", want.last_sequence, got.last_sequence);
          compare_field("sequence_known", 64'(want.sequence_known),
                        64'(got.sequence_known));
          compare_field("gap_present", 64'(want.gap_present), 64'(got.gap_present));
          compare_field("gap_event", 64'(want.gap_event), 64'(got.gap_event));
          compare_field("gap_expected", want.gap_expected, got.gap_expected);
          compare_field("gap_actual", want.gap_actual, got.gap_actual);
          compare_field("gap_count", want.gap_count, got.gap_count);
          compare_field("gap_timestamp", 64'(want.gap_timestamp), 64'(got.gap_timestamp));
          compare_field("resync_event", 64'(want.resync_event), 64'(got.resync_event));
        end
      end
    end
  end

  always @(negedge clk_i) begin : driver
    logic calm_in;
    logic calm_out;
    calm_in  = beats_in >= 700 && beats_in < 1100;
    calm_out = beats_out >= 700 && beats_out < 1100;
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (feed_q.size() != 0 && (calm_in || $urandom_range(0, 99) >= 9)) begin
          in_data_i  <= feed_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= calm_out || $urandom_range(0, 99) >= 9;
    end
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  hot_ids [6];
    logic [63:0] gen_last [256];
    logic        gen_known [256];
    logic [63:0] seq;
    logic [63:0] r64;
    logic [7:0]  id;
    int unsigned pick;

    hot_ids = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd255};
    for (int unsigned k = 0; k < gst_pkg::CONTRACTS; k++) forget_contract(k);
    for (int k = 0; k < 256; k++) begin
      gen_last[k]  = '0;
      gen_known[k] = 1'b0;
    end

    queue_beat(gst_pkg::CMD_QUERY,     8'd0,   64'd0,       63'd0);
    queue_beat(gst_pkg::CMD_DELTA,     8'd0,   64'd100,     63'd0);
    queue_beat(gst_pkg::CMD_DELTA,     8'd0,   64'd101,     63'd5);
    queue_beat(gst_pkg::CMD_DELTA,     8'd0,   64'd105,     TS_MAX);
    queue_beat(gst_pkg::CMD_DELTA,     8'd0,   64'd102,     63'd7);
    queue_beat(gst_pkg::CMD_DELTA,     8'd0,   64'd102,     63'd8);
    queue_beat(gst_pkg::CMD_DELTA,     8'd0,   64'd50,      63'd9);
    queue_beat(gst_pkg::CMD_SNAPSHOT,  8'd0,   64'd200,     63'd0);
    queue_beat(gst_pkg::CMD_RESYNC,    8'd0,   64'd0,       63'd0);
    queue_beat(gst_pkg::CMD_DELTA,     8'd0,   64'd201,     63'd10);
    queue_beat(gst_pkg::CMD_SNAPSHOT,  8'd255, SEQ_MAX,     TS_MAX);
    queue_beat(gst_pkg::CMD_DELTA,     8'd255, SEQ_MAX,     TS_MAX);
    queue_beat(gst_pkg::CMD_DELTA,     8'd255, 64'd0,       63'd1);
    queue_beat(gst_pkg::CMD_DELTA,     8'd255, SEQ_MAX,     TS_MAX);
    queue_beat(CMD_SPARE6,             8'd255, SEQ_MAX,     TS_MAX);
    queue_beat(CMD_SPARE7,             8'd255, 64'd3,       63'd3);
    queue_beat(gst_pkg::CMD_CLEAR,     8'd255, 64'd0,       63'd0);
    queue_beat(gst_pkg::CMD_QUERY,     8'd255, SEQ_MAX,     TS_MAX);
    queue_beat(gst_pkg::CMD_SNAPSHOT,  8'd7,   SEQ_MAX - 1, 63'd0);
    queue_beat(gst_pkg::CMD_DELTA,     8'd7,   SEQ_MAX,     63'd11);
    queue_beat(gst_pkg::CMD_DELTA,     8'd7,   64'd0,       63'd12);
    queue_beat(gst_pkg::CMD_CLEAR_ALL, 8'd0,   64'd0,       63'd0);
    queue_beat(gst_pkg::CMD_QUERY,     8'd7,   64'd0,       63'd0);
    queue_beat(gst_pkg::CMD_DELTA,     8'd7,   SEQ_MAX,     TS_MAX);

    for (int n = 0; n < 1850; n++) begin
      id   = ($urandom_range(0, 99) < 80) ? hot_ids[$urandom_range(0, 5)] : 8'($urandom);
      r64  = {$urandom(), $urandom()};
      pick = $urandom_range(0, 99);
      if (pick < 71 && !gen_known[id]) begin
        seq = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()} : 64'($urandom_range(0, 1000));
        queue_beat(gst_pkg::CMD_DELTA, id, seq, r64[62:0]);
        gen_last[id]  = seq;
        gen_known[id] = 1'b1;
      end else if (pick < 55) begin
        seq = gen_last[id] + 64'd1;
        queue_beat(gst_pkg::CMD_DELTA, id, seq, r64[62:0]);
        gen_last[id] = seq;
      end else if (pick < 63) begin
        seq = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()}
                                          : gen_last[id] + 64'd2 + 64'($urandom_range(0, 20));
        queue_beat(gst_pkg::CMD_DELTA, id, seq, r64[62:0]);
      end else if (pick < 68) begin
        seq = gen_last[id] - 64'($urandom_range(0, 3));
        queue_beat(gst_pkg::CMD_DELTA, id, seq, r64[62:0]);
        gen_last[id] = seq;
      end else if (pick < 71) begin
        queue_beat(gst_pkg::CMD_DELTA, id, {$urandom(), $urandom()}, r64[62:0]);
      end else if (pick < 77) begin
        case ($urandom_range(0, 2))
          0:       seq = {$urandom(), $urandom()};
          1:       seq = SEQ_MAX - 64'($urandom_range(0, 4));
          default: seq = 64'($urandom_range(0, 1000));
        endcase
        queue_beat(gst_pkg::CMD_SNAPSHOT, id, seq, r64[62:0]);
        gen_last[id]  = seq;
        gen_known[id] = 1'b1;
      end else if (pick < 82) begin
        queue_beat(gst_pkg::CMD_RESYNC, id, {$urandom(), $urandom()}, r64[62:0]);
      end else if (pick < 86) begin
        queue_beat(gst_pkg::CMD_CLEAR, id, {$urandom(), $urandom()}, r64[62:0]);
        gen_known[id] = 1'b0;
      end else if (pick < 87) begin
        queue_beat(gst_pkg::CMD_CLEAR_ALL, id, {$urandom(), $urandom()}, r64[62:0]);
        for (int k = 0; k < 256; k++) gen_known[k] = 1'b0;
      end else if (pick < 95) begin
        queue_beat(gst_pkg::CMD_QUERY, id, {$urandom(), $urandom()}, r64[62:0]);
      end else begin
        queue_beat($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7, id,
                   {$urandom(), $urandom()}, r64[62:0]);
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/gst_pkg.sv
hw/rtl/gst_front.sv
hw/rtl/gst_queue.sv
hw/rtl/gst_back.sv
hw/rtl/feed_sequence_gap_tracker_top.sv
tb/sv/feed_sequence_gap_tracker_top_test.sv
